// ----- rtl/csd_pkg.sv -----
// Shared types and constants for the color sort dispatcher.
// Used by every module of the block; depends on nothing.
package csd_pkg;

    localparam int PERIOD_W       = 16;
    localparam int RATIO_W        = 7;
    localparam int PROD_W         = PERIOD_W + RATIO_W;
    localparam int COLOR_W        = 2;
    localparam int CNT_W          = 16;
    localparam int OCC_W          = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int RING_SLOTS_DEF = 16;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 7'd80;
    localparam logic [0:0]         REG_RATIO   = 1'b0;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_UNKNOWN = 2'd0,
        COLOR_RED     = 2'd1,
        COLOR_GREEN   = 2'd2,
        COLOR_BLUE    = 2'd3
    } t_color;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_POPA,
        ST_POPB,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/csd_cfg.sv -----
// APB-style configuration register holding the ratio percentage.
// Depends on csd_pkg.
module csd_cfg import csd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [RATIO_W-1:0]    o_ratio
);

    logic [RATIO_W-1:0] r_ratio;
    logic               w_sel_ratio;

    assign w_sel_ratio = (paddr[2] == REG_RATIO);
    assign pready      = 1'b1;
    assign o_ratio     = r_ratio;
    assign prdata      = w_sel_ratio ? {{(APB_DATA_W-RATIO_W){1'b0}}, r_ratio} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_ratio) begin
            r_ratio <= pwdata[RATIO_W-1:0];
        end
    end

endmodule

// ----- rtl/csd_classify.sv -----
// Color classifier: registers the periods and their scaled products at accept,
// then decides the winning channel. Depends on csd_pkg.
module csd_classify import csd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [PERIOD_W-1:0] i_red_period,
    input  logic [PERIOD_W-1:0] i_green_period,
    input  logic [PERIOD_W-1:0] i_blue_period,
    input  logic [RATIO_W-1:0]  i_ratio,
    output t_color              o_color
);

    logic [PERIOD_W-1:0] r_red;
    logic [PERIOD_W-1:0] r_grn;
    logic [PERIOD_W-1:0] r_blu;
    logic [PROD_W-1:0]   r_red100;
    logic [PROD_W-1:0]   r_grn100;
    logic [PROD_W-1:0]   r_blu100;
    logic [PROD_W-1:0]   r_redk;
    logic [PROD_W-1:0]   r_grnk;
    logic [PROD_W-1:0]   r_bluk;
    logic                w_red_win;
    logic                w_grn_win;
    logic                w_blu_win;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red    <= i_red_period;
            r_grn    <= i_green_period;
            r_blu    <= i_blue_period;
            r_red100 <= PROD_W'(i_red_period) * PROD_W'(100);
            r_grn100 <= PROD_W'(i_green_period) * PROD_W'(100);
            r_blu100 <= PROD_W'(i_blue_period) * PROD_W'(100);
            r_redk   <= PROD_W'(i_red_period) * PROD_W'(i_ratio);
            r_grnk   <= PROD_W'(i_green_period) * PROD_W'(i_ratio);
            r_bluk   <= PROD_W'(i_blue_period) * PROD_W'(i_ratio);
        end
    end

    assign w_red_win = (r_red <= r_grn) && (r_red <= r_blu) &&
                       (r_red100 < r_grnk) && (r_red100 < r_bluk);
    assign w_grn_win = (r_grn <= r_red) && (r_grn <= r_blu) &&
                       (r_grn100 < r_redk) && (r_grn100 < r_bluk);
    assign w_blu_win = (r_blu <= r_red) && (r_blu <= r_grn) &&
                       (r_blu100 < r_redk) && (r_blu100 < r_grnk);

    always_comb begin
        if (w_red_win) begin
            o_color = COLOR_RED;
        end else if (w_grn_win) begin
            o_color = COLOR_GREEN;
        end else if (w_blu_win) begin
            o_color = COLOR_BLUE;
        end else begin
            o_color = COLOR_UNKNOWN;
        end
    end

endmodule

// ----- rtl/csd_ring.sv -----
// Color ring memory: one write port, one registered read port, with a bypass
// for a read that meets a write to the same slot. Depends on csd_pkg.
module csd_ring import csd_pkg::*; #(
    parameter  int RING_SLOTS = RING_SLOTS_DEF,
    localparam int PW         = $clog2(RING_SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [PW-1:0]      i_waddr,
    input  logic [COLOR_W-1:0] i_wdata,
    input  logic [PW-1:0]      i_raddr,
    output logic [COLOR_W-1:0] o_rdata
);

    logic [COLOR_W-1:0] r_mem [RING_SLOTS];
    logic [COLOR_W-1:0] r_rdata;
    logic [COLOR_W-1:0] r_fwd_data;
    logic               r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

// ----- rtl/color_sort_dispatcher.sv -----
// Color sort dispatcher: classifies each color reading, queues new colors in a
// ring memory and pops it at the red, blue and clear gate steps of every item.
// An item goes through classify and enqueue, two pops that each use
// the ring memory's single registered read port, and the load of the output
// register, in whose cycle the next item is already accepted. The result waits
// in the output register while the next item is worked on. The ring memory is
// not cleared at reset; only queued slots are ever read.
module color_sort_dispatcher import csd_pkg::*; #(
    parameter  int RING_SLOTS = RING_SLOTS_DEF,
    localparam int PW         = $clog2(RING_SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PERIOD_W-1:0]   i_red_period,
    input  logic [PERIOD_W-1:0]   i_green_period,
    input  logic [PERIOD_W-1:0]   i_blue_period,
    input  logic                  i_red_gate_blocked,
    input  logic                  i_blue_gate_blocked,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COLOR_W-1:0]    o_detected_color,
    output logic                  o_push_red,
    output logic                  o_push_blue,
    output logic                  o_green_passed,
    output logic [CNT_W-1:0]      o_red_total,
    output logic [CNT_W-1:0]      o_green_total,
    output logic [CNT_W-1:0]      o_blue_total,
    output logic [OCC_W-1:0]      o_queued_items,
    output logic                  o_color_dropped
);

    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_SLOTS - 1);

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    t_state             r_state;
    t_state             n_state;
    logic [RATIO_W-1:0] w_ratio;
    t_color             w_color;
    logic [COLOR_W-1:0] w_pop_data;
    logic               w_accept;
    logic               w_out_free;
    logic               w_load_out;
    logic               w_empty;
    logic               mem_we;
    logic [PW-1:0]      mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;
    logic [PW-1:0]      mem_raddr;

    logic               r_rgate;
    logic               r_bgate;
    logic [PW-1:0]      r_head;
    logic [PW-1:0]      n_head;
    logic [PW-1:0]      r_tail;
    logic [PW-1:0]      n_tail;
    logic [COLOR_W-1:0] r_prev;
    logic [COLOR_W-1:0] n_prev;
    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] n_color;
    logic [CNT_W-1:0]   r_red_cnt;
    logic [CNT_W-1:0]   n_red_cnt;
    logic [CNT_W-1:0]   r_grn_cnt;
    logic [CNT_W-1:0]   n_grn_cnt;
    logic [CNT_W-1:0]   r_blu_cnt;
    logic [CNT_W-1:0]   n_blu_cnt;
    logic               r_push_red;
    logic               n_push_red;
    logic               r_push_blue;
    logic               n_push_blue;
    logic               r_green;
    logic               n_green;
    logic               r_drop;
    logic               n_drop;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [PW:0]        w_occ;
    logic [PW+OCC_W:0]  w_occ_x;

    csd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ratio (w_ratio)
    );

    csd_classify u_classify (
        .i_clk          (i_clk),
        .i_load         (w_accept),
        .i_red_period   (i_red_period),
        .i_green_period (i_green_period),
        .i_blue_period  (i_blue_period),
        .i_ratio        (w_ratio),
        .o_color        (w_color)
    );

    csd_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (w_pop_data)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_empty    = (r_head == r_tail);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT:  n_state = ST_POPA;
            ST_POPA: n_state = ST_POPB;
            ST_POPB: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = w_accept ? ST_PUT : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_OUT: begin
                o_in_stall = !w_out_free;
                w_load_out = w_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_prev      = r_prev;
        n_color     = r_color;
        n_red_cnt   = r_red_cnt;
        n_grn_cnt   = r_grn_cnt;
        n_blu_cnt   = r_blu_cnt;
        n_push_red  = r_push_red;
        n_push_blue = r_push_blue;
        n_green     = r_green;
        n_drop      = r_drop;
        mem_we      = 1'b0;
        mem_waddr   = r_tail;
        mem_wdata   = w_pop_data;
        mem_raddr   = r_head;
        case (r_state)
            ST_PUT: begin
                n_color     = w_color;
                n_prev      = w_color;
                n_push_red  = 1'b0;
                n_push_blue = 1'b0;
                n_green     = 1'b0;
                n_drop      = 1'b0;
                if ((w_color != t_color'(r_prev)) && (w_color != COLOR_UNKNOWN)) begin
                    if (f_next(r_tail) == r_head) begin
                        n_drop = 1'b1;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = w_color;
                        n_tail    = f_next(r_tail);
                    end
                end
            end
            ST_POPA: begin
                if (r_rgate && !w_empty) begin
                    n_head = f_next(r_head);
                    if (w_pop_data == COLOR_RED) begin
                        n_push_red = 1'b1;
                        n_red_cnt  = r_red_cnt + 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_tail = f_next(r_tail);
                    end
                end
                mem_raddr = n_head;
            end
            ST_POPB: begin
                if ((r_bgate || !r_rgate) && !w_empty) begin
                    n_head = f_next(r_head);
                    if (r_bgate && (w_pop_data == COLOR_BLUE)) begin
                        n_push_blue = 1'b1;
                        n_blu_cnt   = r_blu_cnt + 1'b1;
                    end else if (w_pop_data == COLOR_GREEN) begin
                        n_green   = 1'b1;
                        n_grn_cnt = r_grn_cnt + 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_tail = f_next(r_tail);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_occ = (r_tail >= r_head) ? ({1'b0, r_tail} - {1'b0, r_head})
                 : ({1'b0, r_tail} + (PW+1)'(RING_SLOTS) - {1'b0, r_head});
    assign w_occ_x = {{OCC_W{1'b0}}, w_occ};

    always_comb begin
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_prev      <= COLOR_UNKNOWN;
            r_red_cnt   <= '0;
            r_grn_cnt   <= '0;
            r_blu_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_prev      <= n_prev;
            r_red_cnt   <= n_red_cnt;
            r_grn_cnt   <= n_grn_cnt;
            r_blu_cnt   <= n_blu_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color     <= n_color;
        r_push_red  <= n_push_red;
        r_push_blue <= n_push_blue;
        r_green     <= n_green;
        r_drop      <= n_drop;
        if (w_accept) begin
            r_rgate <= i_red_gate_blocked;
            r_bgate <= i_blue_gate_blocked;
        end
        if (w_load_out) begin
            o_detected_color <= r_color;
            o_push_red       <= r_push_red;
            o_push_blue      <= r_push_blue;
            o_green_passed   <= r_green;
            o_red_total      <= r_red_cnt;
            o_green_total    <= r_grn_cnt;
            o_blue_total     <= r_blu_cnt;
            o_queued_items   <= w_occ_x[OCC_W-1:0];
            o_color_dropped  <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= LAST_SLOT) && (r_tail <= LAST_SLOT))
        else $error("Ring pointer outside the ring.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == ST_POPA) || (r_state == ST_POPB)) |=>
        ($stable(r_red_cnt) && $stable(r_grn_cnt) && $stable(r_blu_cnt)))
        else $error("Counter changed outside a pop step.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POPA) && !r_rgate |=> $stable(r_head) && $stable(r_tail))
        else $error("Ring moved at the red step with the red gate clear.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("Result presented outside the output load step.");
`endif

endmodule
